// File: hdl/pdl_pkg.sv
`default_nettype none
package pdl_pkg;

    localparam int CODE_LENGTH_DEF = 8;

    localparam logic [7:0] KEY_TERM   = 8'd13;
    localparam logic [7:0] KEY_OPEN   = 8'h2B;
    localparam logic [7:0] KEY_CHANGE = 8'h2D;

    localparam logic [3:0] MOTOR_OPENING = 4'd12;
    localparam logic [3:0] MOTOR_CLOSING = 4'd6;

    localparam logic OP_KEY  = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam logic [1:0] REPLY_REJECT   = 2'd0;
    localparam logic [1:0] REPLY_OK       = 2'd1;
    localparam logic [1:0] REPLY_LOCK_END = 2'd2;

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_WRONG = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD      = 1'd1;
    localparam int CFG_DATA_W = 8;

    localparam logic [3:0] MAX_WRONG_RST = 4'd2;
    localparam logic [7:0] HOLD_RST      = 8'd60;

    typedef struct packed {
        logic       opcode;
        logic [7:0] key_byte;
    } t_in;

    typedef struct packed {
        logic       reply_valid;
        logic [1:0] reply_code;
        logic [3:0] motor_pattern;
        logic       led_lit;
    } t_out;

    // controller -> datapath
    typedef struct packed {
        logic capture;  // take the input transfer
        logic exec;     // run one step (all but the code compare)
        logic cmp_rd;   // issue one compare read
        logic cmp_end;  // finish the compare and apply its outcome
        logic push;     // move the result into the output register
    } t_ctl_cmd;

    // datapath -> controller
    typedef struct packed {
        logic need_cmp;
        logic rd_last;
        logic out_free;
    } t_ctl_sts;

endpackage
`default_nettype wire

// File: hdl/pdl_ram.sv
`default_nettype none
module pdl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// File: hdl/pdl_ctrl.sv
`default_nettype none
module pdl_ctrl
    import pdl_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    input  wire t_ctl_sts i_sts,
    output t_ctl_cmd      o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_CMP,
        S_END,
        S_PUSH
    } t_state;

    t_state r_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE: if (i_in_valid) r_state <= S_EXEC;
                S_EXEC: r_state <= i_sts.need_cmp ? S_CMP : S_PUSH;
                S_CMP:  if (i_sts.rd_last) r_state <= S_END;
                S_END:  r_state <= S_PUSH;
                S_PUSH: if (i_sts.out_free) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready    = (r_state == S_IDLE);
    assign o_cmd.capture = (r_state == S_IDLE) && i_in_valid;
    assign o_cmd.exec    = (r_state == S_EXEC);
    assign o_cmd.cmp_rd  = (r_state == S_CMP);
    assign o_cmd.cmp_end = (r_state == S_END);
    assign o_cmd.push    = (r_state == S_PUSH);

endmodule
`default_nettype wire

// File: hdl/pdl_dp.sv
`default_nettype none
module pdl_dp
    import pdl_pkg::*;
#(
    parameter int CODE_LENGTH = CODE_LENGTH_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_in                   i_in_data,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output t_out                       o_out_data,
    input  wire t_ctl_cmd              i_cmd,
    output t_ctl_sts                   o_sts
);

    localparam int POS_W  = $clog2(CODE_LENGTH + 1);
    localparam int ADDR_W = (CODE_LENGTH > 1) ? $clog2(CODE_LENGTH) : 1;
    localparam logic [POS_W-1:0]  POS_FULL = POS_W'(CODE_LENGTH);
    localparam logic [ADDR_W-1:0] LAST_IDX = ADDR_W'(CODE_LENGTH - 1);

    typedef enum logic [1:0] {
        M_SETUP,
        M_IDLE,
        M_CHANGE,
        M_OPEN
    } t_mode;

    // configuration
    logic [3:0] r_max_wrong;
    logic [7:0] r_hold;

    // captured item
    logic       r_op;
    logic [7:0] r_key;

    // lock state
    t_mode      r_mode,  n_mode;
    logic [POS_W-1:0] r_pos, n_pos;
    logic [3:0] r_wrong, n_wrong;
    logic       r_timer, n_timer;
    logic [7:0] r_tick,  n_tick;
    logic       r_door,  n_door;
    logic       r_led,   n_led;
    logic [3:0] r_motor, n_motor;
    logic       r_rv,    n_rv;
    logic [1:0] r_rc,    n_rc;

    // compare sweep
    logic [ADDR_W-1:0] r_rd_idx;
    logic              r_chk;
    logic              r_mism;

    // output register
    logic r_out_valid;
    t_out r_out;

    logic [7:0] stored_rd, entry_rd;
    logic       code_we, stored_we, entry_we;
    logic       pos_full, match;
    logic [7:0] tick_inc;
    logic [3:0] wrong_inc;

    // digits land in the entry RAM during an open attempt, otherwise in the
    // stored code (first setup and code change)
    assign pos_full  = (r_pos >= POS_FULL);
    assign code_we   = i_cmd.exec && (r_op == OP_KEY) && !r_timer && !pos_full
                       && (r_mode != M_IDLE);
    assign entry_we  = code_we && (r_mode == M_OPEN);
    assign stored_we = code_we && (r_mode != M_OPEN);

    pdl_ram #(.WIDTH(8), .DEPTH(CODE_LENGTH)) u_stored (
        .i_clk   (i_clk),
        .i_we    (stored_we),
        .i_waddr (r_pos[ADDR_W-1:0]),
        .i_wdata (r_key),
        .i_raddr (r_rd_idx),
        .o_rdata (stored_rd)
    );

    pdl_ram #(.WIDTH(8), .DEPTH(CODE_LENGTH)) u_entry (
        .i_clk   (i_clk),
        .i_we    (entry_we),
        .i_waddr (r_pos[ADDR_W-1:0]),
        .i_wdata (r_key),
        .i_raddr (r_rd_idx),
        .o_rdata (entry_rd)
    );

    assign match     = !r_mism && (stored_rd == entry_rd);
    assign tick_inc  = r_tick + 8'd1;
    assign wrong_inc = (r_wrong == 4'd15) ? r_wrong : r_wrong + 4'd1;

    assign o_sts.need_cmp = (r_op == OP_KEY) && !r_timer && r_mode == M_OPEN
                            && pos_full && (r_key == KEY_TERM);
    assign o_sts.rd_last  = (r_rd_idx == LAST_IDX);
    assign o_sts.out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_mode  = r_mode;
        n_pos   = r_pos;
        n_wrong = r_wrong;
        n_timer = r_timer;
        n_tick  = r_tick;
        n_door  = r_door;
        n_led   = r_led;
        n_motor = r_motor;
        n_rv    = r_rv;
        n_rc    = r_rc;
        if (i_cmd.exec) begin
            n_rv = 1'b0;
            n_rc = REPLY_REJECT;
            if (r_op == OP_TICK) begin
                if (r_timer) begin
                    if (!r_door) n_led = !r_led;
                    n_tick = tick_inc;
                    if (tick_inc == r_hold) begin
                        if (r_door) begin
                            n_motor = MOTOR_CLOSING;
                            n_door  = 1'b0;
                            n_rc    = REPLY_OK;
                        end else begin
                            n_led   = 1'b0;
                            n_wrong = 4'd0;
                            n_rc    = REPLY_LOCK_END;
                        end
                        n_rv    = 1'b1;
                        n_tick  = 8'd0;
                        n_timer = 1'b0;
                        n_mode  = M_IDLE;
                        n_pos   = '0;
                    end
                end
            end else if (!r_timer) begin
                if (r_mode == M_IDLE) begin
                    if (r_key == KEY_CHANGE) begin
                        n_mode = M_CHANGE;
                        n_pos  = '0;
                    end else if (r_key == KEY_OPEN) begin
                        n_mode = M_OPEN;
                        n_pos  = '0;
                    end
                end else if (!pos_full) begin
                    n_pos = r_pos + POS_W'(1);
                end else if (r_key == KEY_TERM && r_mode != M_OPEN) begin
                    // setup or change finished
                    n_mode = M_IDLE;
                    n_pos  = '0;
                    n_rv   = 1'b1;
                    n_rc   = REPLY_OK;
                end
            end
        end else if (i_cmd.cmp_end) begin
            if (match) begin
                n_wrong = 4'd0;
                n_motor = MOTOR_OPENING;
                n_door  = 1'b1;
                n_timer = 1'b1;
                n_tick  = 8'd0;
                n_mode  = M_IDLE;
                n_pos   = '0;
                n_rv    = 1'b1;
                n_rc    = REPLY_OK;
            end else begin
                n_wrong = wrong_inc;
                n_pos   = '0;
                if (wrong_inc >= r_max_wrong) begin
                    // lockout: silent, LED starts dark
                    n_tick  = 8'd0;
                    n_timer = 1'b1;
                    n_led   = 1'b0;
                    n_mode  = M_IDLE;
                end else begin
                    n_rv = 1'b1;
                    n_rc = REPLY_REJECT;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_wrong <= MAX_WRONG_RST;
            r_hold      <= HOLD_RST;
            r_mode      <= M_SETUP;
            r_pos       <= '0;
            r_wrong     <= 4'd0;
            r_timer     <= 1'b0;
            r_tick      <= 8'd0;
            r_door      <= 1'b0;
            r_led       <= 1'b0;
            r_motor     <= 4'd0;
            r_rv        <= 1'b0;
            r_rc        <= REPLY_REJECT;
            r_chk       <= 1'b0;
            r_mism      <= 1'b0;
            r_rd_idx    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_MAX_WRONG: r_max_wrong <= i_cfg_data[3:0];
                    CFG_HOLD:      r_hold      <= i_cfg_data;
                    default: ;
                endcase
            end
            r_mode  <= n_mode;
            r_pos   <= n_pos;
            r_wrong <= n_wrong;
            r_timer <= n_timer;
            r_tick  <= n_tick;
            r_door  <= n_door;
            r_led   <= n_led;
            r_motor <= n_motor;
            r_rv    <= n_rv;
            r_rc    <= n_rc;

            r_chk <= i_cmd.cmp_rd;
            if (i_cmd.exec) begin
                r_rd_idx <= '0;
                r_mism   <= 1'b0;
            end else begin
                if (i_cmd.cmp_rd && r_rd_idx != LAST_IDX) r_rd_idx <= r_rd_idx + ADDR_W'(1);
                if (r_chk && stored_rd != entry_rd) r_mism <= 1'b1;
            end

            if (i_cmd.push && o_sts.out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op  <= i_in_data.opcode;
            r_key <= i_in_data.key_byte;
        end
        if (i_cmd.push && o_sts.out_free) begin
            r_out.reply_valid   <= r_rv;
            r_out.reply_code    <= r_rc;
            r_out.motor_pattern <= r_motor;
            r_out.led_lit       <= r_led;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
`default_nettype wire

// File: hdl/password_door_lock_controller.sv
`default_nettype none
// Combination lock controller. Each input transfer carries a key byte
// (opcode 0) or a one-second tick (opcode 1) and yields exactly one result
// transfer: reply flag and code (0 reject, 1 accepted / code stored / door
// closed, 2 lockout over), the held motor pattern and the LED level. After
// reset the first CODE_LENGTH bytes plus CR (13) set the code; then '-'
// changes it and '+' starts an open attempt. A stray byte instead of CR is
// dropped. An item is captured, stepped and then pushed to the output
// register; a CR that ends an open attempt adds, between step and push,
// the byte-per-cycle compare sweep over the two code RAMs and a finishing
// step. The push waits while the output register holds an unread result.
// One item is in work at a time; the next is taken while the last result
// waits in the output register. Config (index 0 max wrong tries, index 1
// hold seconds) is written through a plain write port; the user must write it
// only while the block is idle, which the block itself does not enforce.
module password_door_lock_controller
    import pdl_pkg::*;
#(
    parameter int CODE_LENGTH = CODE_LENGTH_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // item in
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire t_in                   i_in_data,
    // result out
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output t_out                       o_out_data,
    // config writes
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_ctl_cmd cmd;
    t_ctl_sts sts;

    // sequencer: capture, step, compare sweep, result push
    pdl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // lock state, code memories, timer, output register
    pdl_dp #(.CODE_LENGTH(CODE_LENGTH)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cmd       (cmd),
        .o_sts       (sts)
    );

endmodule
`default_nettype wire
